@@ rtl/spectrum_hann_smoother_unit_macros.svh @@
// assertion macros used by the checker file of the hann smoother
`ifndef SPECTRUM_HANN_SMOOTHER_UNIT_MACROS_SVH
`define SPECTRUM_HANN_SMOOTHER_UNIT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define SHS_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is low
`define SHS_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/shs_pkg.sv @@
// shared constants, types and functions of the hann spectrum smoother
`timescale 1ns / 1ps

package shs_pkg;

  localparam int unsigned SAMPLE_BITS = 24;
  localparam int unsigned COEF_BITS   = 18;
  localparam int unsigned HW_BITS     = 6;
  localparam int unsigned W_DEPTH     = 2 ** HW_BITS;
  localparam int unsigned DL_AW       = HW_BITS + 1;
  localparam int unsigned DL_DEPTH    = 2 ** DL_AW;
  localparam int unsigned CNT_BITS    = HW_BITS + 1;
  localparam int unsigned ACC_BITS    = SAMPLE_BITS + COEF_BITS + CNT_BITS;

  // serial divider sizing: angle numerator pi*j + d/2 needs 37 bits
  localparam int unsigned DIV_BITS = 38;
  localparam int unsigned DVS_BITS = 8;

  // pi and one in q30
  localparam logic [31:0] PI_Q30  = 32'd3373259426;
  localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

  // weight table write port
  typedef struct packed {
    logic                 en;
    logic [HW_BITS-1:0]   addr;
    logic [COEF_BITS-1:0] data;
  } coef_wr_t;

  // taylor cosine term divisors (2n-1)*2n
  function automatic logic [DVS_BITS-1:0] taylor_div(input logic [2:0] n);
    logic [DVS_BITS-1:0] r;
    case (n)
      3'd7: r = 8'd182;
      3'd6: r = 8'd132;
      3'd5: r = 8'd90;
      3'd4: r = 8'd56;
      3'd3: r = 8'd30;
      3'd2: r = 8'd12;
      3'd1: r = 8'd2;
      default: r = 8'd1;
    endcase
    return r;
  endfunction

endpackage

@@ rtl/shs_ram.sv @@
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps

module shs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/shs_coef_gen.sv @@
// hann weight generator: fixed point taylor cosine with a shared serial divider
`timescale 1ns / 1ps

module shs_coef_gen (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [shs_pkg::HW_BITS-1:0]  half_width_i,
  output logic                         busy_o,
  output shs_pkg::coef_wr_t            wr_o
);

  import shs_pkg::*;

  localparam logic [3:0] G_IDLE  = 4'd0;
  localparam logic [3:0] G_ANG   = 4'd1;
  localparam logic [3:0] G_ANGW  = 4'd2;
  localparam logic [3:0] G_SQ    = 4'd3;
  localparam logic [3:0] G_A2    = 4'd4;
  localparam logic [3:0] G_MUL   = 4'd5;
  localparam logic [3:0] G_TRM   = 4'd6;
  localparam logic [3:0] G_TRMW  = 4'd7;
  localparam logic [3:0] G_WDIV  = 4'd8;
  localparam logic [3:0] G_WDIVW = 4'd9;

  localparam logic [61:0] A2_HALF = 62'(1) << 29;

  logic [3:0]          state_q, state_d;
  logic [HW_BITS-1:0]  k_q, k_d;
  logic [HW_BITS-1:0]  hw_q;
  logic                neg_q;
  logic [30:0]         a_q;
  logic [61:0]         sq_q;
  logic [31:0]         a2_q;
  logic [2:0]          n_q;
  logic [30:0]         t_q;
  logic [62:0]         pm_q;

  // serial restoring divider
  logic [5:0]          div_cnt_q;
  logic [DVS_BITS-1:0] div_rem_q;
  logic [DIV_BITS-1:0] div_quo_q;
  logic [DVS_BITS-1:0] div_dvs_q;
  logic                div_start;
  logic [DIV_BITS-1:0] div_dend;
  logic [DVS_BITS-1:0] div_dvs;
  logic                div_done;
  logic [DVS_BITS:0]   div_shift;
  logic                div_ge;
  logic [DVS_BITS-1:0] div_rem_nxt;

  logic [DVS_BITS-1:0] d_val;
  logic                fold;
  logic [DVS_BITS-1:0] j_val;
  logic [DIV_BITS-1:0] ang_num;
  logic [32:0]         tdiff;
  logic [30:0]         t_clamp;
  logic [31:0]         num;
  logic [61:0]         a2_sum;

  assign div_done    = (div_cnt_q == '0);
  assign div_shift   = {div_rem_q, div_quo_q[DIV_BITS-1]};
  assign div_ge      = div_shift >= {1'b0, div_dvs_q};
  assign div_rem_nxt = div_ge ? DVS_BITS'(div_shift - {1'b0, div_dvs_q})
                              : div_shift[DVS_BITS-1:0];

  assign d_val   = DVS_BITS'(hw_q) + DVS_BITS'(1);
  assign fold    = DVS_BITS'({k_q, 1'b0}) > d_val;
  assign j_val   = fold ? (d_val - DVS_BITS'(k_q)) : DVS_BITS'(k_q);
  assign ang_num = DIV_BITS'(PI_Q30) * DIV_BITS'(j_val) + DIV_BITS'(d_val >> 1);
  assign tdiff   = {2'b00, ONE_Q30} - {1'b0, div_quo_q[31:0]};
  assign t_clamp = tdiff[32] ? '0 : tdiff[30:0];
  assign num     = neg_q ? (32'(ONE_Q30) - 32'(t_q)) : (32'(ONE_Q30) + 32'(t_q));
  assign a2_sum  = sq_q + A2_HALF;
  assign busy_o  = (state_q != G_IDLE);

  always_comb begin
    state_d   = state_q;
    k_d       = k_q;
    div_start = 1'b0;
    div_dend  = '0;
    div_dvs   = '0;
    wr_o      = '0;
    case (state_q)
      G_IDLE: begin
        if (start_i) begin
          k_d     = '0;
          state_d = G_ANG;
        end
      end
      G_ANG: begin
        div_start = 1'b1;
        div_dend  = ang_num;
        div_dvs   = d_val;
        state_d   = G_ANGW;
      end
      G_ANGW: begin
        if (div_done) begin
          state_d = G_SQ;
        end
      end
      G_SQ: state_d = G_A2;
      G_A2: state_d = G_MUL;
      G_MUL: state_d = G_TRM;
      G_TRM: begin
        div_start = 1'b1;
        div_dend  = DIV_BITS'(pm_q[62:30]);
        div_dvs   = taylor_div(n_q);
        state_d   = G_TRMW;
      end
      G_TRMW: begin
        if (div_done) begin
          state_d = (n_q == 3'd1) ? G_WDIV : G_MUL;
        end
      end
      G_WDIV: begin
        div_start = 1'b1;
        div_dend  = DIV_BITS'(num[31:12]) + DIV_BITS'(hw_q) + DIV_BITS'(1);
        div_dvs   = DVS_BITS'({hw_q, 1'b1}) + DVS_BITS'(1);
        state_d   = G_WDIVW;
      end
      G_WDIVW: begin
        if (div_done) begin
          wr_o.en   = 1'b1;
          wr_o.addr = k_q;
          wr_o.data = div_quo_q[COEF_BITS-1:0];
          if (k_q == hw_q) begin
            state_d = G_IDLE;
          end else begin
            k_d     = k_q + HW_BITS'(1);
            state_d = G_ANG;
          end
        end
      end
      default: state_d = G_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= G_IDLE;
      k_q       <= '0;
      div_cnt_q <= '0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      if (div_start) begin
        div_cnt_q <= 6'(DIV_BITS);
      end else if (!div_done) begin
        div_cnt_q <= div_cnt_q - 6'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (div_start) begin
      div_rem_q <= '0;
      div_quo_q <= div_dend;
      div_dvs_q <= div_dvs;
    end else if (!div_done) begin
      div_rem_q <= div_rem_nxt;
      div_quo_q <= {div_quo_q[DIV_BITS-2:0], div_ge};
    end
    if (state_q == G_IDLE && start_i) begin
      hw_q <= half_width_i;
    end
    if (state_q == G_ANG) begin
      neg_q <= fold;
    end
    if (state_q == G_ANGW && div_done) begin
      a_q <= div_quo_q[30:0];
    end
    if (state_q == G_SQ) begin
      sq_q <= 62'(a_q) * 62'(a_q);
    end
    if (state_q == G_A2) begin
      a2_q <= a2_sum[61:30];
      n_q  <= 3'd7;
      t_q  <= ONE_Q30;
    end
    if (state_q == G_MUL) begin
      pm_q <= 63'(a2_q) * 63'(t_q);
    end
    if (state_q == G_TRMW && div_done) begin
      t_q <= t_clamp;
      if (n_q != 3'd1) begin
        n_q <= n_q - 3'd1;
      end
    end
  end

endmodule

@@ rtl/spectrum_hann_smoother_unit.sv @@
// top level of the hann window spectrum smoother
//
//  channel   dir  handshake                      payload
//  s_axis    in   s_axis_tvalid / s_axis_tready  tdata = in_sample, tlast = in_last
//  m_axis    out  m_axis_tvalid / m_axis_tready  tdata = out_value, tuser = out_smoothed,
//                                                tlast = out_last
//  cfg       in   cfg_valid_i / cfg_ready_o      cfg_data_i = half_width
//
//  one bin at a time: a smoothed bin is summed tap by tap by the single multiply-accumulate
//  walking the delay-line memory port; a bin passed unchanged is read once
//  the final bin then flushes the pending bins, one read each
//  a half_width write rebuilds the weights, half_width+1 weights one after another,
//  with the input held off until done
//  reset clears control only; the memories come up undefined and are never read unwritten
//  a stalled output register holds the engine only when it has the next result ready
`timescale 1ns / 1ps

module spectrum_hann_smoother_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // input stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [shs_pkg::SAMPLE_BITS-1:0] s_axis_tdata,   // [23:0] in_sample
  input  logic                            s_axis_tlast,
  // result stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [shs_pkg::SAMPLE_BITS-1:0] m_axis_tdata,   // [23:0] out_value
  output logic [0:0]                      m_axis_tuser,   // [0] out_smoothed
  output logic                            m_axis_tlast,
  // half_width register write
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [shs_pkg::HW_BITS-1:0]     cfg_data_i
);

  import shs_pkg::*;

  // engine states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECIDE = 3'd1;
  localparam logic [2:0] S_MAC    = 3'd2;
  localparam logic [2:0] S_MACEND = 3'd3;
  localparam logic [2:0] S_FLUSH  = 3'd4;
  localparam logic [2:0] S_RD     = 3'd5;
  localparam logic [2:0] S_RDW    = 3'd6;

  localparam logic [ACC_BITS:0] ROUND_HALF = (ACC_BITS + 1)'(1) << (COEF_BITS - 1);

  logic [2:0]             state_q, state_d;
  logic [DL_AW-1:0]       head_q, head_d;     // newest delay-line entry
  logic [CNT_BITS-1:0]    cnt_q, cnt_d;       // bins seen in this spectrum, saturating
  logic                   last_q, last_d;     // current bin closes the spectrum
  logic [HW_BITS-1:0]     hw_q, hw_d;
  logic [DL_AW-1:0]       off_q, off_d;       // lookback of the bin being passed
  logic                   flush_q, flush_d;
  logic                   plast_q, plast_d;   // last flag of a single passed bin
  logic [DL_AW-1:0]       tap_q, tap_d;

  // mac pipeline: read, multiply, accumulate
  logic                   mac_issue;
  logic                   acc_clr;
  logic                   mac_v1_q, mac_v2_q;
  logic [SAMPLE_BITS+COEF_BITS-1:0] prod_q;
  logic [ACC_BITS-1:0]    acc_q;

  // output register
  logic                   out_load;
  logic [SAMPLE_BITS-1:0] load_val;
  logic                   load_sm;
  logic                   load_last;
  logic                   ovld_q;
  logic [SAMPLE_BITS-1:0] oval_q;
  logic                   osm_q;
  logic                   olast_q;

  logic                   in_acc;
  logic                   cfg_acc;
  logic                   eng_idle;
  logic                   gen_busy;
  logic                   gen_start;
  coef_wr_t               coef_wr;

  logic [DL_AW-1:0]       dl_raddr;
  logic [SAMPLE_BITS-1:0] dl_rdata;
  logic [DL_AW-1:0]       tap_dist;
  logic [HW_BITS-1:0]     w_raddr;
  logic [COEF_BITS-1:0]   w_rdata;

  logic [ACC_BITS:0]      rnd;
  logic [SAMPLE_BITS-1:0] sat_val;
  logic [CNT_BITS-1:0]    top_cnt;

  assign eng_idle      = (state_q == S_IDLE) && !gen_busy;
  assign cfg_ready_o   = eng_idle;
  // a register write wins over a bin offered in the same cycle
  assign s_axis_tready = eng_idle && !cfg_valid_i;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign cfg_acc       = cfg_valid_i && cfg_ready_o;

  // delay line as a circular buffer; lookback n sits at head - n
  assign dl_raddr = (state_q == S_MAC) ? (head_q - tap_q) : (head_q - off_q);
  // weight index is the distance of the tap from the window center
  assign tap_dist = (tap_q >= DL_AW'(hw_q)) ? (tap_q - DL_AW'(hw_q))
                                            : (DL_AW'(hw_q) - tap_q);
  assign w_raddr  = tap_dist[HW_BITS-1:0];

  shs_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (DL_DEPTH)
  ) u_delay_ram (
    .clk_i   (clk_i),
    .we_i    (in_acc),
    .waddr_i (head_q + DL_AW'(1)),
    .wdata_i (s_axis_tdata),
    .raddr_i (dl_raddr),
    .rdata_o (dl_rdata)
  );

  shs_ram #(
    .WIDTH (COEF_BITS),
    .DEPTH (W_DEPTH)
  ) u_weight_ram (
    .clk_i   (clk_i),
    .we_i    (coef_wr.en),
    .waddr_i (coef_wr.addr),
    .wdata_i (coef_wr.data),
    .raddr_i (w_raddr),
    .rdata_o (w_rdata)
  );

  shs_coef_gen u_coef_gen (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (gen_start),
    .half_width_i (cfg_data_i),
    .busy_o       (gen_busy),
    .wr_o         (coef_wr)
  );

  // round half up, then clamp to the sample range
  assign rnd     = {1'b0, acc_q} + ROUND_HALF;
  assign sat_val = (|rnd[ACC_BITS:COEF_BITS+SAMPLE_BITS]) ? '1
                 : rnd[COEF_BITS+SAMPLE_BITS-1:COEF_BITS];

  // pending bins at the end of a spectrum
  assign top_cnt = (cnt_q > CNT_BITS'(hw_q)) ? CNT_BITS'(hw_q) : cnt_q;

  always_comb begin
    state_d   = state_q;
    head_d    = head_q;
    cnt_d     = cnt_q;
    last_d    = last_q;
    hw_d      = hw_q;
    off_d     = off_q;
    flush_d   = flush_q;
    plast_d   = plast_q;
    tap_d     = tap_q;
    mac_issue = 1'b0;
    acc_clr   = 1'b0;
    gen_start = 1'b0;
    out_load  = 1'b0;
    load_val  = dl_rdata;
    load_sm   = 1'b0;
    load_last = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (cfg_acc) begin
          // new window: rebuild weights, start a fresh spectrum
          hw_d      = cfg_data_i;
          cnt_d     = '0;
          gen_start = 1'b1;
        end else if (in_acc) begin
          head_d  = head_q + DL_AW'(1);
          cnt_d   = (&cnt_q) ? cnt_q : cnt_q + CNT_BITS'(1);
          last_d  = s_axis_tlast;
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (cnt_q > CNT_BITS'(hw_q)) begin
          if (hw_q != '0 && cnt_q >= {hw_q, 1'b1}) begin
            tap_d   = '0;
            acc_clr = 1'b1;
            state_d = S_MAC;
          end else begin
            // edge bin or pass-through: the bin half_width back
            off_d   = DL_AW'(hw_q);
            plast_d = last_q && (hw_q == '0);
            flush_d = 1'b0;
            state_d = S_RD;
          end
        end else if (last_q) begin
          state_d = S_FLUSH;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_MAC: begin
        mac_issue = 1'b1;
        if (tap_q == {hw_q, 1'b0}) begin
          state_d = S_MACEND;
        end else begin
          tap_d = tap_q + DL_AW'(1);
        end
      end
      S_MACEND: begin
        // wait for the pipeline to drain and the output to free up
        if (!mac_v1_q && !mac_v2_q && !ovld_q) begin
          out_load = 1'b1;
          load_val = sat_val;
          load_sm  = 1'b1;
          state_d  = last_q ? S_FLUSH : S_IDLE;
        end
      end
      S_FLUSH: begin
        if (top_cnt == '0) begin
          cnt_d   = '0;
          state_d = S_IDLE;
        end else begin
          off_d   = DL_AW'(top_cnt - CNT_BITS'(1));
          flush_d = 1'b1;
          state_d = S_RD;
        end
      end
      S_RD: begin
        if (!ovld_q) begin
          state_d = S_RDW;
        end
      end
      S_RDW: begin
        out_load  = 1'b1;
        load_last = flush_q ? (off_q == '0) : plast_q;
        if (flush_q) begin
          if (off_q == '0) begin
            cnt_d   = '0;
            flush_d = 1'b0;
            state_d = S_IDLE;
          end else begin
            off_d   = off_q - DL_AW'(1);
            state_d = S_RD;
          end
        end else begin
          state_d = last_q ? S_FLUSH : S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      head_q   <= '0;
      cnt_q    <= '0;
      last_q   <= 1'b0;
      hw_q     <= '0;
      off_q    <= '0;
      flush_q  <= 1'b0;
      plast_q  <= 1'b0;
      tap_q    <= '0;
      mac_v1_q <= 1'b0;
      mac_v2_q <= 1'b0;
      ovld_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      head_q   <= head_d;
      cnt_q    <= cnt_d;
      last_q   <= last_d;
      hw_q     <= hw_d;
      off_q    <= off_d;
      flush_q  <= flush_d;
      plast_q  <= plast_d;
      tap_q    <= tap_d;
      mac_v1_q <= mac_issue;
      mac_v2_q <= mac_v1_q;
      if (out_load) begin
        ovld_q <= 1'b1;
      end else if (m_axis_tready) begin
        ovld_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (mac_v1_q) begin
      prod_q <= (SAMPLE_BITS + COEF_BITS)'(dl_rdata) * (SAMPLE_BITS + COEF_BITS)'(w_rdata);
    end
    if (acc_clr) begin
      acc_q <= '0;
    end else if (mac_v2_q) begin
      acc_q <= acc_q + ACC_BITS'(prod_q);
    end
    if (out_load) begin
      oval_q  <= load_val;
      osm_q   <= load_sm;
      olast_q <= load_last;
    end
  end

  assign m_axis_tvalid = ovld_q;
  assign m_axis_tdata  = oval_q;
  assign m_axis_tuser  = osm_q;
  assign m_axis_tlast  = olast_q;

endmodule

@@ rtl/shs_checker.sv @@
// port-level checker for the hann spectrum smoother, bound to the top level
`timescale 1ns / 1ps
`include "spectrum_hann_smoother_unit_macros.svh"

module shs_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [shs_pkg::SAMPLE_BITS-1:0] m_axis_tdata,
  input logic [0:0]                      m_axis_tuser,
  input logic                            m_axis_tlast,
  input logic                            cfg_valid_i,
  input logic                            cfg_ready_o
);

  logic                            in_txn;
  logic                            cfg_txn;
  logic                            out_stall;
  logic                            out_smoothed;
  logic [shs_pkg::SAMPLE_BITS+2:0] out_word;

  assign in_txn       = s_axis_tvalid && s_axis_tready;
  assign cfg_txn      = cfg_valid_i && cfg_ready_o;
  assign out_stall    = m_axis_tvalid && !m_axis_tready;
  assign out_smoothed = m_axis_tvalid && m_axis_tuser[0];
  assign out_word     = {m_axis_tvalid, m_axis_tlast, m_axis_tuser, m_axis_tdata};

  // a waiting result keeps its payload
  `SHS_ASSERT_NEXT(a_out_hold, out_stall, $stable(out_word), "result changed while stalled")

  // one bin at a time: no input right after an accepted one
  `SHS_ASSERT_NEXT(a_in_seq, in_txn, !s_axis_tready, "input accepted while a bin is in work")

  // weight rebuild holds off the input
  `SHS_ASSERT_NEXT(a_cfg_busy, cfg_txn, !s_axis_tready && !cfg_ready_o, "input open in rebuild")

  // the closing bin of a spectrum is never a smoothed one
  `SHS_ASSERT_IMPL(a_last_edge, out_smoothed, !m_axis_tlast, "smoothed result marked last")

endmodule

bind spectrum_hann_smoother_unit shs_checker u_shs_checker (.*);

@@ tb/testbench.sv @@
// self-checking testbench of the hann window spectrum smoother
`timescale 1ns / 1ps

module testbench;

  // ------------------------------------------------------------------------
  // constants of the smoother arithmetic
  // ------------------------------------------------------------------------
  localparam int unsigned SMP_W    = shs_pkg::SAMPLE_BITS;
  localparam int unsigned HW_W     = shs_pkg::HW_BITS;
  localparam int unsigned TAP_CNT  = 127;            // 2*63+1 taps
  localparam int unsigned COEF_CNT = 64;
  localparam int unsigned SEEN_MAX = 127;            // bin counter saturates here
  localparam int unsigned COEF_FRAC = 18;            // q0.18 weights

  localparam longint unsigned PI_Q30_TB  = 64'd3373259426;
  localparam longint          ONE_Q30_TB = 64'sd1073741824;
  localparam longint unsigned SMP_MAX    = 64'hFF_FFFF;

  // cycles to let an engine that owes no result go quiet before a register write
  localparam int unsigned SETTLE_CYCLES = 200;
  // extra cycles after the last expected bin before the verdict
  localparam int unsigned TAIL_CYCLES   = 300;
  localparam int unsigned RANDOM_BINS   = 200;

  // ------------------------------------------------------------------------
  // types
  // ------------------------------------------------------------------------
  // one entry of the feed: either an input bin or a half_width write
  typedef struct {
    logic             is_cfg;
    logic [SMP_W-1:0] sample;
    logic             last;
    logic [HW_W-1:0]  half_width;
  } feed_item_t;

  // one smoothed or passed-through output bin
  typedef struct packed {
    logic [SMP_W-1:0] value;
    logic             smoothed;
    logic             last;
  } out_bin_t;

  typedef enum logic [2:0] {
    DRV_IDLE,    // nothing in flight
    DRV_GAP,     // idling before the next input transaction
    DRV_SEND,    // input valid held until accepted
    DRV_DRAIN,   // waiting for the block to go idle before a write
    DRV_CFG      // config write valid held until accepted
  } drv_state_e;

  // ------------------------------------------------------------------------
  // block ports
  // ------------------------------------------------------------------------
  logic             clk_i         = 1'b0;
  logic             rst_ni;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [SMP_W-1:0] s_axis_tdata  = '0;   // [23:0] in_sample
  logic             s_axis_tlast  = 1'b0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [SMP_W-1:0] m_axis_tdata;         // [23:0] out_value
  logic [0:0]       m_axis_tuser;         // [0] out_smoothed
  logic             m_axis_tlast;
  logic             cfg_valid_i   = 1'b0;
  logic             cfg_ready_o;
  logic [HW_W-1:0]  cfg_data_i    = '0;

  spectrum_hann_smoother_unit i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ------------------------------------------------------------------------
  // shadow state of the smoother
  // ------------------------------------------------------------------------
  logic [SMP_W-1:0]     taps [TAP_CNT];       // newest bin at entry 0
  logic [COEF_FRAC-1:0] coef [COEF_CNT];      // hann weights indexed by |k|
  logic [HW_W-1:0]      cur_half_width = '0;
  int unsigned          bins_seen = 0;

  out_bin_t    expected_bins [$];
  feed_item_t  bin_feed [$];
  int unsigned fault_count = 0;

  initial begin
    for (int i = 0; i < TAP_CNT; i++) taps[i] = '0;
    for (int i = 0; i < COEF_CNT; i++) coef[i] = '0;
  end

  // q30 cosine of k*pi/d by a seven-term taylor series, folded to [0, pi/2]
  function automatic longint hann_cos_q30(input int unsigned k, input int unsigned d);
    longint unsigned ang, ang2;
    longint          t, p;
    int unsigned     j;
    bit              neg;
    j   = k;
    neg = 1'b0;
    if (2 * k > d) begin
      j   = d - k;
      neg = 1'b1;
    end
    ang  = (PI_Q30_TB * longint'(j) + longint'(d / 2)) / longint'(d);
    ang2 = (ang * ang + (64'd1 << 29)) >> 30;
    t = ONE_Q30_TB;
    for (int n = 7; n >= 1; n--) begin
      p = (longint'(ang2) * t) / ONE_Q30_TB;
      t = ONE_Q30_TB - p / longint'((2 * n - 1) * (2 * n));
    end
    if (t < 0) t = 0;
    if (t > ONE_Q30_TB) t = ONE_Q30_TB;
    return neg ? -t : t;
  endfunction

  // a half_width write rebuilds the weights and starts a fresh spectrum
  task hann_set_half_width(input logic [HW_W-1:0] h);
    longint unsigned num, den, w;
    cur_half_width = h;
    bins_seen      = 0;
    for (int k = 0; k < COEF_CNT; k++) coef[k] = '0;
    if (h != 0) begin
      for (int k = 0; k <= h; k++) begin
        num = longint'(ONE_Q30_TB + hann_cos_q30(k, h + 1));
        den = longint'(2 * h + 2) << 30;
        w   = ((num << COEF_FRAC) + den / 2) / den;
        coef[k] = w[COEF_FRAC-1:0];
      end
    end
  endtask

  // windowed sum centered on tap half_width, rounded and clamped
  function automatic logic [SMP_W-1:0] hann_window_sum();
    longint unsigned acc;
    int unsigned     idx;
    acc = 0;
    for (int a = 0; a <= 2 * cur_half_width; a++) begin
      idx = (a > cur_half_width) ? a - cur_half_width : cur_half_width - a;
      acc += longint'(taps[a]) * longint'(coef[idx]);
    end
    acc = (acc + (64'd1 << (COEF_FRAC - 1))) >> COEF_FRAC;
    return (acc > SMP_MAX) ? SMP_MAX[SMP_W-1:0] : acc[SMP_W-1:0];
  endfunction

  // shift one accepted bin in and queue every output bin it causes
  task hann_push_bin(input logic [SMP_W-1:0] sample, input logic last);
    int unsigned cnt, top;
    logic        fin;
    for (int a = TAP_CNT - 1; a > 0; a--) taps[a] = taps[a-1];
    taps[0] = sample;
    if (bins_seen < SEEN_MAX) bins_seen++;
    cnt = bins_seen;
    if (cnt > cur_half_width) begin
      // only pass-through mode marks the lone result of the final bin
      fin = last && (cur_half_width == 0);
      if (cur_half_width != 0 && cnt >= 2 * cur_half_width + 1)
        expected_bins.push_back({hann_window_sum(), 1'b1, fin});
      else
        expected_bins.push_back({taps[cur_half_width], 1'b0, fin});
    end
    if (last) begin
      // flush the pending tail unchanged, oldest first
      top = (cnt > cur_half_width) ? cur_half_width : cnt;
      for (int a = top; a > 0; a--)
        expected_bins.push_back({taps[a-1], 1'b0, (a == 1)});
      bins_seen = 0;
    end
  endtask

  // ------------------------------------------------------------------------
  // idle draw shared by both sides: mostly a random wait, with bursts of none
  // ------------------------------------------------------------------------
  function automatic int unsigned draw_wait(inout int unsigned burst);
    if (burst != 0) begin
      burst--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      burst = $urandom_range(10, 30);
      return 0;
    end
    return $urandom_range(0, 10);
  endfunction

  task note_fault(input string what, input out_bin_t want, input out_bin_t got);
    fault_count++;
    if (fault_count <= 10)
      $display("%0t %s: expected value %h smoothed %b last %b, got value %h smoothed %b last %b",
               $realtime, what, want.value, want.smoothed, want.last,
               got.value, got.smoothed, got.last);
  endtask

  // ------------------------------------------------------------------------
  // driver: input stream and config channel, fed from bin_feed
  // ------------------------------------------------------------------------
  drv_state_e  drv_state = DRV_IDLE;
  feed_item_t  drv_item;
  int unsigned drv_wait  = 0;
  int unsigned drv_burst = 0;

  always @(posedge clk_i or negedge rst_ni) begin : bin_driver
    logic             nxt_valid, nxt_last, nxt_cfg_valid;
    logic [SMP_W-1:0] nxt_data;
    logic [HW_W-1:0]  nxt_cfg;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tlast  <= 1'b0;
      cfg_valid_i   <= 1'b0;
      cfg_data_i    <= '0;
      drv_state      = DRV_IDLE;
      drv_wait       = 0;
    end else begin
      // next values are worked out first so each port gets one assignment
      nxt_valid     = s_axis_tvalid;
      nxt_data      = s_axis_tdata;
      nxt_last      = s_axis_tlast;
      nxt_cfg_valid = cfg_valid_i;
      nxt_cfg       = cfg_data_i;

      // input transaction: predict what it causes
      if (s_axis_tvalid && s_axis_tready) begin
        hann_push_bin(s_axis_tdata, s_axis_tlast);
        nxt_valid = 1'b0;
        drv_state = DRV_IDLE;
      end
      // config transaction
      if (cfg_valid_i && cfg_ready_o) begin
        hann_set_half_width(cfg_data_i);
        nxt_cfg_valid = 1'b0;
        drv_state     = DRV_IDLE;
      end

      // pick up the next feed entry in the same cycle, so gap 0 is back to back
      if (drv_state == DRV_IDLE && bin_feed.size() != 0) begin
        drv_item  = bin_feed.pop_front();
        drv_wait  = drv_item.is_cfg ? 0 : draw_wait(drv_burst);
        drv_state = drv_item.is_cfg ? DRV_DRAIN : DRV_GAP;
      end

      case (drv_state)
        DRV_GAP: begin
          if (drv_wait == 0) begin
            nxt_valid = 1'b1;
            nxt_data  = drv_item.sample;
            nxt_last  = drv_item.last;
            drv_state = DRV_SEND;
          end else begin
            drv_wait--;
          end
        end
        DRV_DRAIN: begin
          // write only once every result is out and the engine had time to settle
          if (expected_bins.size() != 0) begin
            drv_wait = 0;
          end else if (drv_wait >= SETTLE_CYCLES) begin
            nxt_cfg_valid = 1'b1;
            nxt_cfg       = drv_item.half_width;
            drv_state     = DRV_CFG;
          end else begin
            drv_wait++;
          end
        end
        default: ;
      endcase

      s_axis_tvalid <= nxt_valid;
      s_axis_tdata  <= nxt_data;
      s_axis_tlast  <= nxt_last;
      cfg_valid_i   <= nxt_cfg_valid;
      cfg_data_i    <= nxt_cfg;
    end
  end

  // ------------------------------------------------------------------------
  // monitor: result stream with random back-pressure, checks every bin
  // ------------------------------------------------------------------------
  int unsigned mon_wait  = 0;
  int unsigned mon_burst = 0;

  always @(posedge clk_i or negedge rst_ni) begin : bin_monitor
    logic     nxt_ready;
    out_bin_t got, want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      mon_wait       = 0;
    end else begin
      nxt_ready = m_axis_tready;
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tdata, m_axis_tuser[0], m_axis_tlast};
        if (expected_bins.size() == 0) begin
          note_fault("unexpected bin", '0, got);
        end else begin
          want = expected_bins.pop_front();
          if (got !== want) note_fault("bin mismatch", want, got);
        end
        // stall drawn per result
        mon_wait  = draw_wait(mon_burst);
        nxt_ready = (mon_wait == 0);
      end else if (!m_axis_tready) begin
        if (mon_wait != 0) mon_wait--;
        if (mon_wait == 0) nxt_ready = 1'b1;
      end
      m_axis_tready <= nxt_ready;
    end
  end

  // ------------------------------------------------------------------------
  // feed builders
  // ------------------------------------------------------------------------
  task queue_bin(input logic [SMP_W-1:0] sample, input logic last);
    bin_feed.push_back('{is_cfg: 1'b0, sample: sample, last: last, half_width: '0});
  endtask

  task queue_half_width(input logic [HW_W-1:0] h);
    bin_feed.push_back('{is_cfg: 1'b1, sample: '0, last: 1'b0, half_width: h});
  endtask

  // mostly random amplitudes with the range ends thrown in
  function automatic logic [SMP_W-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return SMP_W'($urandom_range(0, 24'hFF_FFFF));
    endcase
  endfunction

  // one spectrum; with_last clear leaves it open so the next write drops it
  task queue_spectrum(input int unsigned len, input bit with_last, input bit all_max);
    for (int i = 0; i < len; i++)
      queue_bin(all_max ? '1 : pick_sample(), with_last && (i == len - 1));
  endtask

  // ------------------------------------------------------------------------
  // stimulus, reset and end of run
  // ------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned     random_bins;
    int unsigned     n_spec, len;
    logic [HW_W-1:0] h;
    bit              closed;

    // directed: pass-through mode right after reset, range ends
    queue_bin(24'h00_0000, 1'b0);
    queue_bin(24'hFF_FFFF, 1'b0);
    queue_bin(24'h5A_5A5A, 1'b1);
    queue_bin(24'h00_0001, 1'b1);           // one-bin spectrum
    // narrow window: spectrum shorter than the window, then saturating sums
    queue_half_width(6'd2);
    queue_bin(24'h80_0000, 1'b0);
    queue_bin(24'h7F_FFFF, 1'b0);
    queue_bin(24'hA5_A5A5, 1'b1);
    queue_spectrum(7, 1'b1, 1'b1);
    // open spectrum dropped by a write
    queue_spectrum(4, 1'b0, 1'b0);
    // widest window, short spectrum
    queue_half_width(6'd63);
    queue_bin(24'hFF_FFFF, 1'b0);
    queue_bin(24'h12_3456, 1'b0);
    queue_bin(24'h00_0000, 1'b1);
    // three-tap window
    queue_half_width(6'd1);
    queue_bin(24'h00_0000, 1'b0);
    queue_bin(24'hFF_FFFF, 1'b0);
    queue_bin(24'h00_0000, 1'b1);

    // random phases: a write, then one to three spectra
    random_bins = 0;
    while (random_bins < RANDOM_BINS) begin
      case ($urandom_range(0, 7))
        0:       h = 6'd63;
        1:       h = HW_W'($urandom_range(0, 63));
        2:       h = 6'd0;
        default: h = HW_W'($urandom_range(1, 6));
      endcase
      queue_half_width(h);
      n_spec = $urandom_range(1, 3);
      for (int s = 0; s < n_spec; s++) begin
        // now and then a spectrum long enough to saturate the bin counter
        if ($urandom_range(0, 9) == 0) len = $urandom_range(128, 150);
        else                           len = $urandom_range(1, 2 * h + 12);
        closed = !(s == n_spec - 1 && $urandom_range(0, 3) == 0);
        queue_spectrum(len, closed, ($urandom_range(0, 19) == 0));
        random_bins += len;
      end
    end

    // reset, released away from the active edge
    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // all feed entries accepted
    while (bin_feed.size() != 0 || drv_state != DRV_IDLE) @(posedge clk_i);
    // every expected bin delivered, then a quiet tail to catch strays
    while (expected_bins.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (expected_bins.size() != 0) begin
      fault_count++;
      $display("%0d expected bins never arrived", expected_bins.size());
    end
    if (fault_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

  // watchdog well above the slowest legal run
  initial begin : watchdog
    #30ms;
    $display("timeout waiting for the smoother");
    $display("testbench: FAIL");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl
rtl/shs_pkg.sv
rtl/shs_ram.sv
rtl/shs_coef_gen.sv
rtl/spectrum_hann_smoother_unit.sv
rtl/shs_checker.sv
tb/testbench.sv
